// ----- hw/rtl/smt_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, widths and codes for the stepper motion tracker.
package smt_pkg;

    localparam int FRAC_BITS = 16;
    localparam int POS_W     = 48;
    localparam int RATE_W    = 32;
    localparam int TIME_W    = 64;
    localparam int ID_W      = 16;
    localparam int STEPS_W   = 32;
    localparam int SPR_W     = 16;
    localparam int MSC_W     = 8;

    localparam int SPLIT_W  = 32;
    localparam int PROD_W   = RATE_W + SPLIT_W;
    localparam int LO_SHIFT = SPLIT_W - FRAC_BITS;
    localparam int LO_W     = PROD_W - LO_SHIFT;
    localparam int SUM_W    = ((POS_W > LO_W) ? POS_W : LO_W) + 1;

    localparam int DATA_W    = 32;
    localparam int ADDR_W    = 4;
    localparam int REG_IDX_W = 2;

    localparam logic [RATE_W-1:0] STEP_RATE_RST = RATE_W'(3221225);
    localparam logic [SPR_W-1:0]  SPR_RST       = SPR_W'(200);
    localparam logic [MSC_W-1:0]  MSC_RST       = MSC_W'(16);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        REQ_ENABLE = 2'd0,
        REQ_MOVE   = 2'd1,
        REQ_TICK   = 2'd2,
        REQ_NONE   = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BUSY     = 2'd1,
        ST_DISABLED = 2'd2
    } t_status;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_STEP_RATE     = 2'd0,
        REG_STEPS_PER_ROT = 2'd1,
        REG_MICROSTEP_CNT = 2'd2
    } t_reg;

    typedef struct packed {
        t_req              kind;
        logic [ID_W-1:0]   id;
        logic              en;
        logic              dir;
        logic [POS_W-1:0]  load;
        logic [TIME_W-1:0] delta;
    } t_s1;

    typedef struct packed {
        t_req              kind;
        logic [ID_W-1:0]   id;
        logic              en;
        logic              dir;
        logic [POS_W-1:0]  load;
        logic [PROD_W-1:0] p_lo;
        logic [PROD_W-1:0] p_hi;
    } t_s2;

    typedef struct packed {
        t_req             kind;
        logic [ID_W-1:0]  id;
        logic             en;
        logic             dir;
        logic [POS_W-1:0] amount;
    } t_item;

    typedef struct packed {
        t_status          status;
        logic             cmd_done;
        logic [ID_W-1:0]  done_id;
        logic             move_done;
        logic [POS_W-1:0] position;
        logic             is_enabled;
    } t_result;

endpackage

// ----- hw/rtl/smt_front.sv -----
`timescale 1ns / 1ps
// Front end: accepts transactions, decodes them and computes the tick advance.
module smt_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [1:0]                    i_req_type,
    input  logic [smt_pkg::ID_W-1:0]      i_cmd_id,
    input  logic                          i_enable_value,
    input  logic                          i_direction,
    input  logic [smt_pkg::STEPS_W-1:0]   i_move_steps,
    input  logic [smt_pkg::TIME_W-1:0]    i_timestamp,
    input  logic [smt_pkg::RATE_W-1:0]    i_step_rate,
    output logic                          o_push_valid,
    output smt_pkg::t_item                o_push_item,
    input  logic                          i_push_ready
);

    logic                          r_s1_valid;
    logic                          r_s2_valid;
    smt_pkg::t_s1                  r_s1;
    smt_pkg::t_s2                  r_s2;
    logic [smt_pkg::TIME_W-1:0]    r_last_time;
    smt_pkg::t_s1                  n_s1;
    smt_pkg::t_s2                  n_s2;
    logic                          s1_go;
    logic                          s1_free;
    logic                          s2_go;
    logic                          s2_free;
    logic                          in_take;
    logic                          load_over;
    logic [smt_pkg::STEPS_W+smt_pkg::FRAC_BITS-1:0] load_full;
    logic                          hi_over;
    logic [smt_pkg::POS_W-1:0]     hi_part;
    logic [smt_pkg::PROD_W-1:0]    lo_part;
    logic [smt_pkg::SUM_W-1:0]     sum;
    logic [smt_pkg::POS_W-1:0]     adv;

    always_comb begin
        s2_go   = r_s2_valid && i_push_ready;
        s2_free = !r_s2_valid || s2_go;
        s1_go   = r_s1_valid && s2_free;
        s1_free = !r_s1_valid || s1_go;
        in_take = i_in_valid && s1_free;
    end

    assign o_in_stall = !s1_free;

    always_comb begin
        load_over  = |(i_move_steps >> (smt_pkg::POS_W - smt_pkg::FRAC_BITS));
        load_full  = {i_move_steps, {smt_pkg::FRAC_BITS{1'b0}}};
        n_s1.kind  = smt_pkg::t_req'(i_req_type);
        n_s1.id    = i_cmd_id;
        n_s1.en    = i_enable_value;
        n_s1.dir   = i_direction;
        n_s1.load  = load_over ? '1 : smt_pkg::POS_W'(load_full);
        n_s1.delta = i_timestamp - r_last_time;
    end

    always_comb begin
        n_s2.kind = r_s1.kind;
        n_s2.id   = r_s1.id;
        n_s2.en   = r_s1.en;
        n_s2.dir  = r_s1.dir;
        n_s2.load = r_s1.load;
        n_s2.p_lo = smt_pkg::PROD_W'(i_step_rate)
                    * smt_pkg::PROD_W'(r_s1.delta[smt_pkg::SPLIT_W-1:0]);
        n_s2.p_hi = smt_pkg::PROD_W'(i_step_rate)
                    * smt_pkg::PROD_W'(r_s1.delta[smt_pkg::TIME_W-1:smt_pkg::SPLIT_W]);
    end

    always_comb begin
        hi_over = |(r_s2.p_hi >> (smt_pkg::POS_W - smt_pkg::FRAC_BITS));
        hi_part = smt_pkg::POS_W'(r_s2.p_hi << smt_pkg::FRAC_BITS);
        lo_part = r_s2.p_lo >> smt_pkg::LO_SHIFT;
        sum     = smt_pkg::SUM_W'(hi_part) + smt_pkg::SUM_W'(lo_part);
        adv     = (hi_over || (|(sum >> smt_pkg::POS_W))) ? '1 : smt_pkg::POS_W'(sum);
        o_push_item.kind   = r_s2.kind;
        o_push_item.id     = r_s2.id;
        o_push_item.en     = r_s2.en;
        o_push_item.dir    = r_s2.dir;
        o_push_item.amount = (r_s2.kind == smt_pkg::REQ_TICK) ? adv : r_s2.load;
    end

    assign o_push_valid = r_s2_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_last_time <= '0;
        end else begin
            if (s1_free) begin
                r_s1_valid <= i_in_valid;
            end
            if (s2_free) begin
                r_s2_valid <= r_s1_valid;
            end
            if (in_take && (n_s1.kind == smt_pkg::REQ_TICK)) begin
                r_last_time <= i_timestamp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1 <= n_s1;
        end
        if (s1_go) begin
            r_s2 <= n_s2;
        end
    end

endmodule

// ----- hw/rtl/smt_fifo.sv -----
`timescale 1ns / 1ps
// Short queue between the front end and the back end.
module smt_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    input  smt_pkg::t_item i_push_item,
    output logic           o_push_ready,
    output logic           o_pop_valid,
    output smt_pkg::t_item o_pop_item,
    input  logic           i_pop_ready
);

    smt_pkg::t_item               r_mem [smt_pkg::QUEUE_DEPTH];
    logic [smt_pkg::QPTR_W-1:0]   r_wr_ptr;
    logic [smt_pkg::QPTR_W-1:0]   r_rd_ptr;
    logic [smt_pkg::QCNT_W-1:0]   r_count;
    logic [smt_pkg::QCNT_W-1:0]   n_count;
    logic                         push;
    logic                         pop;

    function automatic logic [smt_pkg::QPTR_W-1:0] ptr_next(
        input logic [smt_pkg::QPTR_W-1:0] ptr
    );
        if (ptr == smt_pkg::QPTR_W'(smt_pkg::QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return ptr + smt_pkg::QPTR_W'(1);
    endfunction

    assign o_push_ready = (r_count != smt_pkg::QCNT_W'(smt_pkg::QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_item   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_comb begin
        case ({push, pop})
            2'b10:   n_count = r_count + smt_pkg::QCNT_W'(1);
            2'b01:   n_count = r_count - smt_pkg::QCNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (push) begin
                r_wr_ptr <= ptr_next(r_wr_ptr);
            end
            if (pop) begin
                r_rd_ptr <= ptr_next(r_rd_ptr);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= smt_pkg::QCNT_W'(smt_pkg::QUEUE_DEPTH))
        else $error("Queue count exceeds its depth.");
`endif

endmodule

// ----- hw/rtl/smt_back.sv -----
`timescale 1ns / 1ps
// Back end: holds the motion state, executes transactions and registers results.
module smt_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_item_valid,
    input  smt_pkg::t_item   i_item,
    output logic             o_item_ready,
    output logic             o_out_valid,
    output smt_pkg::t_result o_out,
    input  logic             i_out_stall
);

    logic                       r_enabled;
    logic                       r_busy;
    logic [smt_pkg::ID_W-1:0]   r_pending_id;
    logic                       r_backward;
    logic [smt_pkg::POS_W-1:0]  r_remaining;
    logic [smt_pkg::POS_W-1:0]  r_position;
    logic                       r_out_valid;
    smt_pkg::t_result           r_out;
    logic                       n_enabled;
    logic                       n_busy;
    logic [smt_pkg::ID_W-1:0]   n_pending_id;
    logic                       n_backward;
    logic [smt_pkg::POS_W-1:0]  n_remaining;
    logic [smt_pkg::POS_W-1:0]  n_position;
    smt_pkg::t_result           n_out;
    logic [smt_pkg::POS_W-1:0]  adv;
    logic                       take;

    assign o_item_ready = !r_out_valid || !i_out_stall;
    assign take         = i_item_valid && o_item_ready;
    assign o_out_valid  = r_out_valid;
    assign o_out        = r_out;

    always_comb begin
        n_enabled    = r_enabled;
        n_busy       = r_busy;
        n_pending_id = r_pending_id;
        n_backward   = r_backward;
        n_remaining  = r_remaining;
        n_position   = r_position;
        n_out.status    = smt_pkg::ST_OK;
        n_out.cmd_done  = 1'b0;
        n_out.done_id   = '0;
        n_out.move_done = 1'b0;
        adv = (i_item.amount < r_remaining) ? i_item.amount : r_remaining;
        case (i_item.kind)
            smt_pkg::REQ_ENABLE: begin
                if (r_busy) begin
                    n_out.status = smt_pkg::ST_BUSY;
                end else begin
                    n_enabled      = i_item.en;
                    n_out.cmd_done = 1'b1;
                    n_out.done_id  = i_item.id;
                end
            end
            smt_pkg::REQ_MOVE: begin
                if (r_busy) begin
                    n_out.status = smt_pkg::ST_BUSY;
                end else if (!r_enabled) begin
                    n_out.status = smt_pkg::ST_DISABLED;
                end else begin
                    n_backward   = i_item.dir;
                    n_remaining  = i_item.amount;
                    n_busy       = 1'b1;
                    n_pending_id = i_item.id;
                end
            end
            smt_pkg::REQ_TICK: begin
                if (r_remaining != '0) begin
                    n_position  = r_backward ? (r_position - adv) : (r_position + adv);
                    n_remaining = r_remaining - adv;
                end else if (r_busy) begin
                    n_out.cmd_done  = 1'b1;
                    n_out.done_id   = r_pending_id;
                    n_out.move_done = 1'b1;
                    n_busy          = 1'b0;
                end
            end
            default: begin
            end
        endcase
        n_out.position   = n_position;
        n_out.is_enabled = n_enabled;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled    <= 1'b0;
            r_busy       <= 1'b0;
            r_pending_id <= '0;
            r_backward   <= 1'b0;
            r_remaining  <= '0;
            r_position   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (take) begin
                r_enabled    <= n_enabled;
                r_busy       <= n_busy;
                r_pending_id <= n_pending_id;
                r_backward   <= n_backward;
                r_remaining  <= n_remaining;
                r_position   <= n_position;
                r_out_valid  <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= n_out;
        end
    end

`ifndef SYNTH
    a_idle_no_distance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (r_remaining == '0))
        else $error("Distance remains while no move is pending.");

    a_refused_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && r_busy && ((i_item.kind == smt_pkg::REQ_ENABLE)
                            || (i_item.kind == smt_pkg::REQ_MOVE)))
        |=> (r_busy && $stable(r_remaining) && $stable(r_enabled)
             && $stable(r_position)))
        else $error("A refused command changed the motion state.");

    a_complete_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && r_busy && (i_item.kind == smt_pkg::REQ_TICK) && (r_remaining == '0))
        |=> (!r_busy && r_out_valid && r_out.move_done && r_out.cmd_done))
        else $error("Move completion did not clear the pending command.");
`endif

endmodule

// ----- hw/rtl/stepper_motion_tracker.sv -----
`timescale 1ns / 1ps
// Top level of the stepper motion tracker with its configuration registers.
// Results pass the s1 and s2 stages, the queue and the back-end result register.
// Throughput: one transaction per cycle unless a stall holds it; the back end
// updates the motion state for one transaction each cycle, and the tick product
// is pipelined in the front. Reset is synchronous and active low; it clears the
// control state and restores the register defaults at once, with no clearing pass.
module stepper_motion_tracker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [1:0]                           i_req_type,
    input  logic [smt_pkg::ID_W-1:0]             i_cmd_id,
    input  logic                                 i_enable_value,
    input  logic                                 i_direction,
    input  logic [smt_pkg::STEPS_W-1:0]          i_move_steps,
    input  logic [smt_pkg::TIME_W-1:0]           i_timestamp,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [1:0]                           o_status,
    output logic                                 o_cmd_done,
    output logic [smt_pkg::ID_W-1:0]             o_done_id,
    output logic                                 o_move_done,
    output logic signed [smt_pkg::POS_W-1:0]     o_position,
    output logic                                 o_is_enabled,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [smt_pkg::ADDR_W-1:0]           paddr,
    input  logic [smt_pkg::DATA_W-1:0]           pwdata,
    output logic [smt_pkg::DATA_W-1:0]           prdata,
    output logic                                 pready
);

    logic [smt_pkg::RATE_W-1:0] r_step_rate;
    logic [smt_pkg::SPR_W-1:0]  r_steps_per_rotation;
    logic [smt_pkg::MSC_W-1:0]  r_microstep_count;
    smt_pkg::t_reg              reg_idx;
    logic                       cfg_write;
    logic                       push_valid;
    logic                       push_ready;
    smt_pkg::t_item             push_item;
    logic                       pop_valid;
    logic                       pop_ready;
    smt_pkg::t_item             pop_item;
    smt_pkg::t_result           out;

    assign pready    = 1'b1;
    assign reg_idx   = smt_pkg::t_reg'(paddr[smt_pkg::ADDR_W-1:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        case (reg_idx)
            smt_pkg::REG_STEP_RATE:     prdata = smt_pkg::DATA_W'(r_step_rate);
            smt_pkg::REG_STEPS_PER_ROT: prdata = smt_pkg::DATA_W'(r_steps_per_rotation);
            smt_pkg::REG_MICROSTEP_CNT: prdata = smt_pkg::DATA_W'(r_microstep_count);
            default:                    prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_rate          <= smt_pkg::STEP_RATE_RST;
            r_steps_per_rotation <= smt_pkg::SPR_RST;
            r_microstep_count    <= smt_pkg::MSC_RST;
        end else if (cfg_write) begin
            case (reg_idx)
                smt_pkg::REG_STEP_RATE:     r_step_rate <= smt_pkg::RATE_W'(pwdata);
                smt_pkg::REG_STEPS_PER_ROT: r_steps_per_rotation <= smt_pkg::SPR_W'(pwdata);
                smt_pkg::REG_MICROSTEP_CNT: r_microstep_count <= smt_pkg::MSC_W'(pwdata);
                default: begin
                end
            endcase
        end
    end

    smt_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_req_type     (i_req_type),
        .i_cmd_id       (i_cmd_id),
        .i_enable_value (i_enable_value),
        .i_direction    (i_direction),
        .i_move_steps   (i_move_steps),
        .i_timestamp    (i_timestamp),
        .i_step_rate    (r_step_rate),
        .o_push_valid   (push_valid),
        .o_push_item    (push_item),
        .i_push_ready   (push_ready)
    );

    smt_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_item  (push_item),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_pop_item   (pop_item),
        .i_pop_ready  (pop_ready)
    );

    smt_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (pop_valid),
        .i_item       (pop_item),
        .o_item_ready (pop_ready),
        .o_out_valid  (o_out_valid),
        .o_out        (out),
        .i_out_stall  (i_out_stall)
    );

    assign o_status     = out.status;
    assign o_cmd_done   = out.cmd_done;
    assign o_done_id    = out.done_id;
    assign o_move_done  = out.move_done;
    assign o_position   = $signed(out.position);
    assign o_is_enabled = out.is_enabled;

endmodule

// ----- bench/stepper_motion_tracker_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the stepper motion tracker with directed and random traffic.
module stepper_motion_tracker_tb;

    logic                         i_clk          = 1'b0;
    logic                         i_rst_n        = 1'b0;
    logic                         i_in_valid     = 1'b0;
    logic                         i_out_stall    = 1'b0;
    logic [1:0]                   i_req_type     = smt_pkg::REQ_NONE;
    logic [smt_pkg::ID_W-1:0]     i_cmd_id       = '0;
    logic                         i_enable_value = 1'b0;
    logic                         i_direction    = 1'b0;
    logic [smt_pkg::STEPS_W-1:0]  i_move_steps   = '0;
    logic [smt_pkg::TIME_W-1:0]   i_timestamp    = '0;
    logic                         psel           = 1'b0;
    logic                         penable        = 1'b0;
    logic                         pwrite         = 1'b0;
    logic [smt_pkg::ADDR_W-1:0]   paddr          = '0;
    logic [smt_pkg::DATA_W-1:0]   pwdata         = '0;

    logic                         o_in_stall;
    logic                         o_out_valid;
    logic [1:0]                   o_status;
    logic                         o_cmd_done;
    logic [smt_pkg::ID_W-1:0]     o_done_id;
    logic                         o_move_done;
    logic signed [smt_pkg::POS_W-1:0] o_position;
    logic                         o_is_enabled;
    logic [smt_pkg::DATA_W-1:0]   prdata;
    logic                         pready;

    // Tracker state as the checker sees it.
    logic                         motor_enabled   = 1'b0;
    logic                         move_pending    = 1'b0;
    logic [smt_pkg::ID_W-1:0]     pending_cmd_id  = '0;
    logic                         moving_backward = 1'b0;
    logic [smt_pkg::POS_W-1:0]    steps_left      = '0;
    logic [smt_pkg::POS_W-1:0]    position_acc    = '0;
    logic [smt_pkg::TIME_W-1:0]   last_stamp      = '0;
    logic [smt_pkg::DATA_W-1:0]   reg_shadow [3]  = '{32'(smt_pkg::STEP_RATE_RST),
                                                      32'(smt_pkg::SPR_RST),
                                                      32'(smt_pkg::MSC_RST)};

    smt_pkg::t_result             motion_reports [$];
    logic [smt_pkg::TIME_W-1:0]   clock_ns          = '0;
    int                           mismatch_count    = 0;
    int                           items_sent        = 0;
    int                           sender_idle_pct   = 17;
    int                           receiver_idle_pct = 63;

    stepper_motion_tracker uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_req_type     (i_req_type),
        .i_cmd_id       (i_cmd_id),
        .i_enable_value (i_enable_value),
        .i_direction    (i_direction),
        .i_move_steps   (i_move_steps),
        .i_timestamp    (i_timestamp),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_cmd_done     (o_cmd_done),
        .o_done_id      (o_done_id),
        .o_move_done    (o_move_done),
        .o_position     (o_position),
        .o_is_enabled   (o_is_enabled),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [smt_pkg::STEPS_W-1:0] pick_steps();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 75) begin
            return $urandom_range(0, 16);
        end else if (roll < 95) begin
            return $urandom_range(0, 65535);
        end
        return $urandom;
    endfunction

    function automatic logic [smt_pkg::TIME_W-1:0] pick_delta();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45) begin
            return 64'($urandom_range(0, 3000));
        end else if (roll < 75) begin
            return 64'($urandom);
        end else if (roll < 90) begin
            return 64'($urandom_range(0, 255));
        end
        return rand64();
    endfunction

    function automatic smt_pkg::t_result track_request(smt_pkg::t_req kind,
                                                       logic [smt_pkg::ID_W-1:0] id,
                                                       logic en, logic dir,
                                                       logic [smt_pkg::STEPS_W-1:0] steps,
                                                       logic [smt_pkg::TIME_W-1:0] stamp);
        smt_pkg::t_result          r;
        logic [63:0]               load;
        logic [63:0]               delta;
        logic [95:0]               product;
        logic [95:0]               scaled;
        logic [smt_pkg::POS_W-1:0] advance;
        r.status    = smt_pkg::ST_OK;
        r.cmd_done  = 1'b0;
        r.done_id   = '0;
        r.move_done = 1'b0;
        case (kind)
            smt_pkg::REQ_ENABLE, smt_pkg::REQ_MOVE: begin
                if (move_pending) begin
                    r.status = smt_pkg::ST_BUSY;
                end else if (kind == smt_pkg::REQ_ENABLE) begin
                    motor_enabled = en;
                    r.cmd_done    = 1'b1;
                    r.done_id     = id;
                end else if (!motor_enabled) begin
                    r.status = smt_pkg::ST_DISABLED;
                end else begin
                    load            = 64'(steps) << smt_pkg::FRAC_BITS;
                    steps_left      = ((load >> smt_pkg::POS_W) != 0) ? '1
                                                                      : load[smt_pkg::POS_W-1:0];
                    moving_backward = dir;
                    move_pending    = 1'b1;
                    pending_cmd_id  = id;
                end
            end
            smt_pkg::REQ_TICK: begin
                delta = stamp - last_stamp;
                if (steps_left != 0) begin
                    product = 96'(reg_shadow[smt_pkg::REG_STEP_RATE]) * 96'(delta);
                    scaled  = product >> (32 - smt_pkg::FRAC_BITS);
                    advance = ((scaled >> smt_pkg::POS_W) != 0) ? '1
                                                                : scaled[smt_pkg::POS_W-1:0];
                    if (advance > steps_left) begin
                        advance = steps_left;
                    end
                    position_acc = moving_backward ? position_acc - advance
                                                   : position_acc + advance;
                    steps_left   = steps_left - advance;
                end else if (move_pending) begin
                    r.cmd_done   = 1'b1;
                    r.done_id    = pending_cmd_id;
                    r.move_done  = 1'b1;
                    move_pending = 1'b0;
                end
                last_stamp = stamp;
            end
            default: begin
            end
        endcase
        r.position   = position_acc;
        r.is_enabled = motor_enabled;
        return r;
    endfunction

    task automatic note_mismatch(string what, logic [63:0] want, logic [63:0] got);
        $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin : check_results
        smt_pkg::t_result want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (motion_reports.size() == 0) begin
                $display("%0t ns: result mismatch, expected none, actual status %0h position %0h",
                         $time, o_status, o_position);
                mismatch_count++;
            end else begin
                want = motion_reports.pop_front();
                if (o_status !== want.status) begin
                    note_mismatch("status", 64'(want.status), 64'(o_status));
                end
                if (o_cmd_done !== want.cmd_done) begin
                    note_mismatch("cmd_done", 64'(want.cmd_done), 64'(o_cmd_done));
                end
                if (o_done_id !== want.done_id) begin
                    note_mismatch("done_id", 64'(want.done_id), 64'(o_done_id));
                end
                if (o_move_done !== want.move_done) begin
                    note_mismatch("move_done", 64'(want.move_done), 64'(o_move_done));
                end
                if (o_position !== want.position) begin
                    note_mismatch("position", {16'h0, want.position}, {16'h0, o_position});
                end
                if (o_is_enabled !== want.is_enabled) begin
                    note_mismatch("is_enabled", 64'(want.is_enabled), 64'(o_is_enabled));
                end
            end
        end
    end

    task automatic drive_request(input smt_pkg::t_req kind, input logic en, input logic dir,
                                 input logic [smt_pkg::STEPS_W-1:0] steps,
                                 input logic [smt_pkg::TIME_W-1:0] stamp);
        logic [smt_pkg::ID_W-1:0] id;
        id = smt_pkg::ID_W'($urandom);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_req_type     <= kind;
        i_cmd_id       <= id;
        i_enable_value <= en;
        i_direction    <= dir;
        i_move_steps   <= steps;
        i_timestamp    <= stamp;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) begin
            @(posedge i_clk);
        end
        motion_reports.push_back(track_request(kind, id, en, dir, steps, stamp));
        items_sent++;
    endtask

    task automatic send_enable(input logic en);
        drive_request(smt_pkg::REQ_ENABLE, en, 1'($urandom_range(0, 1)), $urandom, rand64());
    endtask

    task automatic send_move(input logic dir, input logic [smt_pkg::STEPS_W-1:0] steps);
        drive_request(smt_pkg::REQ_MOVE, 1'($urandom_range(0, 1)), dir, steps, rand64());
    endtask

    task automatic send_tick(input logic [smt_pkg::TIME_W-1:0] delta);
        clock_ns = clock_ns + delta;
        drive_request(smt_pkg::REQ_TICK, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      $urandom, clock_ns);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (motion_reports.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic apb_transfer(input logic wr, input smt_pkg::t_reg idx,
                                input logic [smt_pkg::DATA_W-1:0] wdata,
                                output logic [smt_pkg::DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= smt_pkg::ADDR_W'({idx, 2'b00});
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1) begin
            @(posedge i_clk);
        end
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic check_reg(input smt_pkg::t_reg idx);
        logic [smt_pkg::DATA_W-1:0] got;
        apb_transfer(1'b0, idx, '0, got);
        if (got !== reg_shadow[idx]) begin
            note_mismatch("register readback", 64'(reg_shadow[idx]), 64'(got));
        end
    endtask

    task automatic write_reg(input smt_pkg::t_reg idx, input logic [smt_pkg::DATA_W-1:0] value);
        logic [smt_pkg::DATA_W-1:0] ignored;
        apb_transfer(1'b1, idx, value, ignored);
        case (idx)
            smt_pkg::REG_STEP_RATE:     reg_shadow[idx] = value;
            smt_pkg::REG_STEPS_PER_ROT: reg_shadow[idx] = value & 32'h0000_FFFF;
            default:                    reg_shadow[idx] = value & 32'h0000_00FF;
        endcase
        check_reg(idx);
    endtask

    task automatic test_register_defaults();
        check_reg(smt_pkg::REG_STEP_RATE);
        check_reg(smt_pkg::REG_STEPS_PER_ROT);
        check_reg(smt_pkg::REG_MICROSTEP_CNT);
    endtask

    task automatic test_enable_and_refusals();
        send_tick(64'd0);
        send_move(1'b0, 32'd5);
        send_enable(1'b1);
        send_move(1'b1, 32'd3);
        send_enable(1'b0);
        send_move(1'b0, 32'd7);
        drive_request(smt_pkg::REQ_NONE, 1'b1, 1'b1, $urandom, rand64());
        send_tick(64'd1000);
        send_tick(64'd200000);
        send_tick(64'd10);
    endtask

    task automatic test_zero_move_and_disable();
        send_move(1'b0, 32'd0);
        send_tick(64'd5);
        send_enable(1'b0);
        send_move(1'b1, 32'd2);
        send_enable(1'b1);
    endtask

    task automatic test_rate_extremes();
        wait_drained();
        write_reg(smt_pkg::REG_STEP_RATE, 32'hFFFF_FFFF);
        write_reg(smt_pkg::REG_STEPS_PER_ROT, 32'h0000_FFFF);
        write_reg(smt_pkg::REG_MICROSTEP_CNT, 32'h0000_00FF);
        // Two saturated full-length moves carry the position past its wrap point.
        send_move(1'b0, 32'hFFFF_FFFF);
        send_tick(64'hFFFF_FFFF_FFFF_FFFF);
        send_tick(64'd1);
        send_move(1'b0, 32'hFFFF_FFFF);
        send_tick(64'hFFFF_FFFF_FFFF_FFFF);
        send_tick(64'd1);
        wait_drained();
        write_reg(smt_pkg::REG_STEP_RATE, 32'h0);
        write_reg(smt_pkg::REG_STEPS_PER_ROT, 32'h0);
        write_reg(smt_pkg::REG_MICROSTEP_CNT, 32'h0);
        send_move(1'b1, 32'd2);
        send_tick(64'hFFFF_FFFF_FFFF_FFFF);
        wait_drained();
        write_reg(smt_pkg::REG_STEP_RATE, 32'(smt_pkg::STEP_RATE_RST));
        write_reg(smt_pkg::REG_STEPS_PER_ROT, 32'(smt_pkg::SPR_RST));
        write_reg(smt_pkg::REG_MICROSTEP_CNT, 32'(smt_pkg::MSC_RST));
        send_tick(64'd100000);
        send_tick(64'd1);
    endtask

    task automatic run_motion_sequence();
        int ticks;
        if (!motor_enabled || $urandom_range(0, 9) == 0) begin
            send_enable(1'b1);
        end
        send_move(1'($urandom_range(0, 1)), pick_steps());
        ticks = 0;
        while (move_pending && ticks < 6) begin
            if ($urandom_range(0, 7) == 0) begin
                if ($urandom_range(0, 1) == 1) begin
                    send_enable(1'($urandom_range(0, 1)));
                end else begin
                    send_move(1'($urandom_range(0, 1)), pick_steps());
                end
            end
            send_tick(pick_delta());
            ticks++;
        end
        if (move_pending && steps_left != 0 && reg_shadow[smt_pkg::REG_STEP_RATE] != 0) begin
            send_tick(64'hFFFF_FFFF_FFFF_FFFF);
        end
        if (move_pending) begin
            send_tick(pick_delta());
        end
        if ($urandom_range(0, 9) == 0) begin
            send_enable(1'b0);
        end
    endtask

    task automatic run_noise_item();
        case ($urandom_range(0, 3))
            0: send_enable(1'($urandom_range(0, 1)));
            1: send_move(1'($urandom_range(0, 1)), pick_steps());
            2: begin
                clock_ns = rand64();
                send_tick(64'd0);
            end
            default: drive_request(smt_pkg::REQ_NONE, 1'($urandom_range(0, 1)),
                                   1'($urandom_range(0, 1)), $urandom, rand64());
        endcase
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct, input int count);
        int stop_at;
        int segment_end;
        logic [smt_pkg::DATA_W-1:0] rate;
        sender_idle_pct   = send_pct;
        receiver_idle_pct = recv_pct;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            wait_drained();
            case ($urandom_range(0, 3))
                0: rate = 32'(smt_pkg::STEP_RATE_RST);
                1: rate = 32'hFFFF_FFFF;
                2: rate = $urandom_range(1, 65535);
                default: rate = $urandom;
            endcase
            write_reg(smt_pkg::REG_STEP_RATE, rate);
            write_reg(smt_pkg::REG_STEPS_PER_ROT, $urandom_range(0, 65535));
            write_reg(smt_pkg::REG_MICROSTEP_CNT, $urandom_range(0, 255));
            segment_end = items_sent + 100;
            while (items_sent < segment_end && items_sent < stop_at) begin
                if ($urandom_range(0, 9) == 0) begin
                    run_noise_item();
                end else begin
                    run_motion_sequence();
                end
                if ($urandom_range(0, 49) == 0) begin
                    wait_drained();
                end
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_register_defaults();
        test_enable_and_refusals();
        test_zero_move_and_disable();
        test_rate_extremes();
        test_random_traffic(17, 63, 400);
        test_random_traffic(63, 17, 400);
        test_random_traffic(0, 0, 400);
        wait_drained();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/smt_pkg.sv
hw/rtl/smt_front.sv
hw/rtl/smt_fifo.sv
hw/rtl/smt_back.sv
hw/rtl/stepper_motion_tracker.sv
bench/stepper_motion_tracker_tb.sv
